/* design/mbq_pkg.sv */
// shared constants, codes and types for the mailbox queue engine
// used by the message store and the top level; no dependencies
`default_nettype none

package mbq_pkg;

    localparam int MAILBOXES   = 16;
    localparam int QUEUE_DEPTH = 15;
    localparam int RING_SIZE   = QUEUE_DEPTH + 1;

    localparam int SLOT_W      = (MAILBOXES > 1) ? $clog2(MAILBOXES) : 1;
    localparam int PTR_W       = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
    localparam int STORE_DEPTH = MAILBOXES * RING_SIZE;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam int OP_W     = 2;
    localparam int ID_W     = 32;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 3;

    localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEND   = 2'd2;
    localparam logic [OP_W-1:0] OP_RECV   = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_UNKNOWN = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EXISTS  = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_NOSLOT  = 3'd5;

    // one access of the message store per cycle at most on each port
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mbq_mem_req_t;

endpackage

`default_nettype wire

/* design/mbq_msg_store.sv */
// message store: one write port, one read port with registered data
// depends on mbq_pkg
`default_nettype none

module mbq_msg_store import mbq_pkg::*; (
    input  wire logic         aclk,
    input  wire mbq_mem_req_t mem_req,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [STORE_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_req.wr_en) begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en) begin
            rd_data_reg <= mem[mem_req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* design/mailbox_table_queue_engine_core.sv */
// top level of the mailbox queue engine: id table, ring pointers and request sequencer
// depends on mbq_pkg and mbq_msg_store
`default_nettype none

// Mailbox queue engine. Each request on the s_ channel (opcode in s_tuser, id and
// message word in s_tdata) gets exactly one response on the m_ channel (status in
// m_tuser, received word in m_tdata, zero unless a receive succeeded). Requests are
// handled one at a time: create, delete and send load the response register from
// S_EXEC, the state entered on acceptance, after which the next request can be taken;
// a successful receive goes on to S_RDATA before loading it, because the word comes
// out of the synchronous message store in the cycle after the read is issued. Id lookup
// compares all mailbox slots in parallel; the response register lets a new request be
// taken while the previous response is still waiting, and a stalled m_ side holds the
// sequencer until the response register frees up. No clearing pass after reset.
module mailbox_table_queue_engine_core import mbq_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [63:0]          s_tdata,   // [31:0] mailbox_id, [63:32] message_in
    input  wire logic [OP_W-1:0]      s_tuser,   // [1:0] opcode
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [WORD_W-1:0]         m_tdata,   // [31:0] message_out
    output logic [STATUS_W-1:0]       m_tuser    // [2:0] status
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_RDATA = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [OP_W-1:0]     op_reg;
    logic [ID_W-1:0]     id_reg;
    logic [WORD_W-1:0]   word_reg;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [WORD_W-1:0]   out_data_reg, out_data_next;

    logic [MAILBOXES-1:0] slot_in_use_reg;
    logic [ID_W-1:0]      slot_id_reg [MAILBOXES];
    logic [PTR_W-1:0]     head_reg [MAILBOXES];
    logic [PTR_W-1:0]     tail_reg [MAILBOXES];

    logic [MAILBOXES-1:0] hit;
    logic                 hit_any, free_any;
    logic [SLOT_W-1:0]    hit_idx, free_idx;
    logic [PTR_W-1:0]     head_cur, tail_cur, head_nxt, tail_nxt;
    logic                 q_full, q_empty, out_free;
    logic                 create_go, delete_go, send_go, recv_go;
    logic [STATUS_W-1:0]  exec_status;
    mbq_mem_req_t         mem_req;
    logic [WORD_W-1:0]    rd_data;

    mbq_msg_store u_store (
        .aclk    (aclk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    // parallel id match; lowest matching slot and lowest free slot win
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = MAILBOXES - 1; i >= 0; i--) begin
            hit[i] = slot_in_use_reg[i] && (slot_id_reg[i] == id_reg);
            if (hit[i]) begin
                hit_idx = SLOT_W'(i);
            end
            if (!slot_in_use_reg[i]) begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign hit_any  = |hit;
    assign free_any = ~&slot_in_use_reg;

    assign head_cur = head_reg[hit_idx];
    assign tail_cur = tail_reg[hit_idx];
    assign head_nxt = (head_cur == PTR_W'(RING_SIZE - 1)) ? '0 : head_cur + 1'b1;
    assign tail_nxt = (tail_cur == PTR_W'(RING_SIZE - 1)) ? '0 : tail_cur + 1'b1;
    assign q_full   = (tail_nxt == head_cur);
    assign q_empty  = (head_cur == tail_cur);

    assign out_free = !out_valid_reg || m_tready;

    // a receive commits as soon as the read is issued; the rest wait for the output
    assign recv_go   = (state_reg == S_EXEC) && (op_reg == OP_RECV) && hit_any && !q_empty;
    assign create_go = (state_reg == S_EXEC) && out_free && (op_reg == OP_CREATE)
                       && !hit_any && free_any;
    assign delete_go = (state_reg == S_EXEC) && out_free && (op_reg == OP_DELETE) && hit_any;
    assign send_go   = (state_reg == S_EXEC) && out_free && (op_reg == OP_SEND)
                       && hit_any && !q_full;

    always_comb begin
        exec_status = STAT_OK;
        if (op_reg == OP_CREATE) begin
            if (hit_any) begin
                exec_status = STAT_EXISTS;
            end else if (!free_any) begin
                exec_status = STAT_NOSLOT;
            end
        end else if (!hit_any) begin
            exec_status = STAT_UNKNOWN;
        end else if (op_reg == OP_SEND && q_full) begin
            exec_status = STAT_FULL;
        end else if (op_reg == OP_RECV && q_empty) begin
            exec_status = STAT_EMPTY;
        end
    end

    always_comb begin
        mem_req.wr_en   = send_go;
        mem_req.wr_addr = ADDR_W'(hit_idx) * ADDR_W'(RING_SIZE) + ADDR_W'(tail_cur);
        mem_req.wr_data = word_reg;
        mem_req.rd_en   = recv_go;
        mem_req.rd_addr = ADDR_W'(hit_idx) * ADDR_W'(RING_SIZE) + ADDR_W'(head_cur);
    end

    always_comb begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (recv_go) begin
                    state_next = S_RDATA;
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = exec_status;
                    out_data_next   = '0;
                    state_next      = S_IDLE;
                end
            end
            S_RDATA: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_data_next   = rd_data;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            slot_in_use_reg <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (create_go) begin
                slot_in_use_reg[free_idx] <= 1'b1;
            end
            if (delete_go) begin
                slot_in_use_reg[hit_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        if (s_tvalid && s_tready) begin
            op_reg   <= s_tuser;
            id_reg   <= s_tdata[ID_W-1:0];
            word_reg <= s_tdata[ID_W +: WORD_W];
        end
        if (create_go) begin
            slot_id_reg[free_idx] <= id_reg;
            head_reg[free_idx]    <= '0;
            tail_reg[free_idx]    <= '0;
        end
        if (send_go) begin
            tail_reg[hit_idx] <= tail_nxt;
        end
        if (recv_go) begin
            head_reg[hit_idx] <= head_nxt;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = out_data_reg;

    // create never admits a duplicate id, so a lookup hits at most one slot
    a_single_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC) |-> $onehot0(hit))
        else $error("more than one slot holds the same id");

    // a word only comes back with an ok status
    a_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg != STAT_OK) |-> (out_data_reg == '0))
        else $error("non-zero word on a failed request");

    // a read return always follows a committed receive
    a_rdata_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RDATA && !$past(state_reg == S_RDATA)) |-> $past(recv_go))
        else $error("read return without a receive");

    // store ports never both active
    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.wr_en |-> !mem_req.rd_en)
        else $error("store read and write in the same cycle");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// self-checking bench for mailbox_table_queue_engine_core: directed then random requests,
// with an in-bench mailbox table predicting every response
// depends on mbq_pkg and the design files under design/
`default_nettype none

module tb_top;
    import mbq_pkg::*;

    localparam int ID_POOL   = 24;
    localparam int HOLD_LONG = 250;

    // mailbox table mirror and the responses it still owes
    class mailbox_scoreboard;
        typedef struct packed {
            logic [STATUS_W-1:0] status;
            logic [WORD_W-1:0]   word;
        } reply_t;

        bit                 in_use [MAILBOXES];
        logic [ID_W-1:0]    box_id [MAILBOXES];
        logic [PTR_W-1:0]   rd_ptr [MAILBOXES];
        logic [PTR_W-1:0]   wr_ptr [MAILBOXES];
        logic [WORD_W-1:0]  ring   [MAILBOXES][RING_SIZE];
        reply_t             replies_due[$];
        int                 errors;

        function new();
            for (int s = 0; s < MAILBOXES; s++) begin
                in_use[s] = 1'b0;
                box_id[s] = '0;
                rd_ptr[s] = '0;
                wr_ptr[s] = '0;
            end
            errors = 0;
        endfunction

        function logic [PTR_W-1:0] ring_step(logic [PTR_W-1:0] p);
            return (p == PTR_W'(RING_SIZE - 1)) ? '0 : p + 1'b1;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                   logic [WORD_W-1:0] word);
            int     hit;
            int     spare;
            reply_t r;
            hit   = -1;
            spare = -1;
            r     = '{status: STAT_OK, word: '0};
            // lowest matching slot in use, lowest free slot
            for (int s = MAILBOXES - 1; s >= 0; s--) begin
                if (in_use[s] && box_id[s] == id) hit = s;
                if (!in_use[s]) spare = s;
            end
            if (op == OP_CREATE) begin
                if (hit >= 0) begin
                    r.status = STAT_EXISTS;
                end else if (spare < 0) begin
                    r.status = STAT_NOSLOT;
                end else begin
                    in_use[spare] = 1'b1;
                    box_id[spare] = id;
                    rd_ptr[spare] = '0;
                    wr_ptr[spare] = '0;
                end
            end else if (hit < 0) begin
                r.status = STAT_UNKNOWN;
            end else begin
                case (op)
                    OP_DELETE: begin
                        in_use[hit] = 1'b0;
                        box_id[hit] = '0;
                        rd_ptr[hit] = '0;
                        wr_ptr[hit] = '0;
                    end
                    OP_SEND: begin
                        if (ring_step(wr_ptr[hit]) == rd_ptr[hit]) begin
                            r.status = STAT_FULL;
                        end else begin
                            ring[hit][wr_ptr[hit]] = word;
                            wr_ptr[hit] = ring_step(wr_ptr[hit]);
                        end
                    end
                    default: begin
                        if (rd_ptr[hit] == wr_ptr[hit]) begin
                            r.status = STAT_EMPTY;
                        end else begin
                            r.word = ring[hit][rd_ptr[hit]];
                            rd_ptr[hit] = ring_step(rd_ptr[hit]);
                        end
                    end
                endcase
            end
            replies_due.push_back(r);
        endfunction

        function void check_response(logic [STATUS_W-1:0] status, logic [WORD_W-1:0] word);
            reply_t r;
            if (replies_due.size() == 0) begin
                $error("response with no request outstanding: status %0d, message_out %08h",
                       status, word);
                errors++;
                return;
            end
            r = replies_due.pop_front();
            if (status !== r.status) begin
                $error("status: expected %0d, got %0d", r.status, status);
                errors++;
            end
            if (word !== r.word) begin
                $error("message_out: expected %08h, got %08h", r.word, word);
                errors++;
            end
        endfunction

        function int pending();
            return replies_due.size();
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata  = '0;
    logic [OP_W-1:0]      s_tuser  = OP_CREATE;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [WORD_W-1:0]    m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    mailbox_scoreboard    sb = new();
    logic [ID_W-1:0]      id_pool [ID_POOL];
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    bit                   hold_start    = 1'b0;
    int                   hold_left     = 0;

    mailbox_table_queue_engine_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #(20 * 400_000);
        $display("DONE: errors detected");
        $finish;
    end

    // response side: check, then choose next ready; long hold-offs counted here
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                sb.check_response(m_tuser, m_tdata);
            end
            if (hold_start) begin
                hold_left  = HOLD_LONG;
                hold_start = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic offer_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                 logic [WORD_W-1:0] word);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {word, id};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, id, word);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        return ($urandom_range(9) == 0) ? ID_W'($urandom()) : id_pool[$urandom_range(ID_POOL - 1)];
    endfunction

    // bursts of well-formed traffic on a small id set, with some noise mixed in
    task automatic play_traffic(int budget);
        int              sent;
        int              kind;
        int              n;
        logic [ID_W-1:0] id;
        logic [OP_W-1:0] op;
        sent = 0;
        while (sent < budget) begin
            kind = $urandom_range(99);
            id   = pick_id();
            if (kind < 20) begin
                n = $urandom_range(1, 5);
                repeat (n) offer_request(OP_CREATE, pick_id(), $urandom());
            end else if (kind < 50) begin
                n = $urandom_range(1, 17);
                repeat (n) offer_request(OP_SEND, id, $urandom());
            end else if (kind < 75) begin
                n = $urandom_range(1, 17);
                repeat (n) offer_request(OP_RECV, id, $urandom());
            end else if (kind < 85) begin
                n = 1;
                offer_request(OP_DELETE, id, $urandom());
            end else begin
                n = $urandom_range(1, 3);
                repeat (n) begin
                    op = OP_W'($urandom_range(3));
                    offer_request(op, $urandom(), $urandom());
                end
            end
            sent += n;
        end
    endtask

    initial begin
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < ID_POOL; i++) id_pool[i] = $urandom();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 24;
        recv_idle_pct = 79;

        // directed: unknown ids, duplicate create, fifo order, slot reuse, dropped words
        offer_request(OP_RECV,   32'h0000_0000, 32'h0000_0000);
        offer_request(OP_DELETE, 32'h0000_0000, 32'hFFFF_FFFF);
        offer_request(OP_SEND,   32'h0000_0000, 32'h1234_5678);
        offer_request(OP_CREATE, 32'h0000_0000, 32'h0000_0000);
        offer_request(OP_CREATE, 32'h0000_0000, 32'h0000_0000);
        offer_request(OP_CREATE, 32'hFFFF_FFFF, 32'h0000_0000);
        offer_request(OP_RECV,   32'h0000_0000, 32'h0000_0000);
        offer_request(OP_SEND,   32'h0000_0000, 32'hFFFF_FFFF);
        offer_request(OP_SEND,   32'h0000_0000, 32'h0000_0000);
        offer_request(OP_SEND,   32'hFFFF_FFFF, 32'h5A5A_5A5A);
        offer_request(OP_RECV,   32'h0000_0000, 32'h0000_0000);
        offer_request(OP_RECV,   32'h0000_0000, 32'h0000_0000);
        offer_request(OP_RECV,   32'h0000_0000, 32'h0000_0000);
        offer_request(OP_DELETE, 32'h0000_0000, 32'h0000_0000);
        offer_request(OP_CREATE, 32'h1234_5678, 32'h0000_0000);
        offer_request(OP_SEND,   32'hFFFF_FFFF, 32'hA5A5_A5A5);
        offer_request(OP_RECV,   32'hFFFF_FFFF, 32'h0000_0000);
        offer_request(OP_DELETE, 32'hFFFF_FFFF, 32'h0000_0000);
        offer_request(OP_CREATE, 32'hFFFF_FFFF, 32'h0000_0000);
        offer_request(OP_RECV,   32'hFFFF_FFFF, 32'h0000_0000);
        offer_request(OP_DELETE, 32'hFFFF_FFFF, 32'h0000_0000);
        offer_request(OP_DELETE, 32'h1234_5678, 32'h0000_0000);

        play_traffic(200);
        wait_drained();
        play_traffic(200);

        wait_drained();
        send_idle_pct = 79;
        recv_idle_pct = 24;
        play_traffic(400);

        // no idling; the response side stalls for a long stretch while requests keep coming
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_start    = 1'b1;
        play_traffic(400);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
design/mbq_pkg.sv
design/mbq_msg_store.sv
design/mailbox_table_queue_engine_core.sv
bench/tb_top.sv
